// ===== rtl/tsre_pkg.sv =====
// Package: types and constants for the Thumb SUB (register) execute block.
package tsre_pkg;

  // Encoding selector
  localparam logic ENC_NARROW = 1'b0;
  localparam logic ENC_WIDE   = 1'b1;

  // PC increments
  localparam logic [2:0] PC_ADV_NARROW = 3'd2;
  localparam logic [2:0] PC_ADV_WIDE   = 3'd4;

  // Narrow form field positions (halfword in bits 31:16)
  localparam int T1_RM_LO = 22;
  localparam int T1_RN_LO = 19;
  localparam int T1_RD_LO = 16;

  // Wide form field positions
  localparam int T2_S_BIT  = 20;
  localparam int T2_RN_LO  = 16;
  localparam int T2_IMM3_LO = 12;
  localparam int T2_RD_LO  = 8;
  localparam int T2_IMM2_LO = 6;
  localparam int T2_TYPE_LO = 4;
  localparam int T2_RM_LO  = 0;

  typedef enum logic [1:0] {
    SHIFT_LSL = 2'd0,
    SHIFT_LSR = 2'd1,
    SHIFT_ASR = 2'd2,
    SHIFT_ROR = 2'd3
  } shift_kind_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] instruction;
    logic        in_it_block;
    logic        condition_passed;
    logic [31:0] rn_value;
    logic [31:0] rm_value;
    logic        carry_in;
  } tsre_in_t;

  typedef struct packed {
    logic [3:0]  dest_reg;
    logic [31:0] result;
    logic        write_enable;
    logic        flags_write;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;
    logic [2:0]  pc_advance;
    logic [3:0]  src_first_reg;
    logic [3:0]  src_second_reg;
  } tsre_out_t;

  // Decoded item, held after the first stage
  typedef struct packed {
    logic [3:0]  rd;
    logic [3:0]  rn_idx;
    logic [3:0]  rm_idx;
    shift_kind_t kind;
    logic [4:0]  amt;
    logic [2:0]  pc_adv;
    logic        exec;
    logic        fw;
    logic [31:0] rn;
    logic [31:0] rm;
    logic        cin;
  } tsre_dec_t;

  // Item with the shifted operand, held after the second stage
  typedef struct packed {
    logic [3:0]  rd;
    logic [3:0]  rn_idx;
    logic [3:0]  rm_idx;
    logic [2:0]  pc_adv;
    logic        exec;
    logic        fw;
    logic [31:0] rn;
    logic [31:0] sh;
  } tsre_shf_t;

endpackage

// ===== rtl/tsre_if.sv =====
// Interfaces: valid/ready channels for instruction items and result items.
interface tsre_in_if;
  import tsre_pkg::*;
  logic     valid;
  logic     ready;
  tsre_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tsre_out_if;
  import tsre_pkg::*;
  logic      valid;
  logic      ready;
  tsre_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/thumb_sub_register_execute.sv =====
// Top level: three-stage Thumb SUB (register) execute pipeline.
//
// Channels: in_ch carries one instruction item (encoding select, raw word,
// IT status, Rn and Rm values, carry flag); out_ch returns exactly one result
// item per instruction: Rd, difference, write and flag-write enables, NZCV,
// PC increment and the decoded Rn/Rm indices.
// Stages: decode, operand shift, subtract and flags. The last stage is the
// output register.
// Flow: an accepted item passes the decode, shift and output registers in order;
// out_ch.valid rises once it is in the output register.
// Throughput: 1 item per cycle while out_ch.ready stays high; set by the three
// stage registers, each of which advances whenever the stage after it is empty or moving.
// Reset: rst_n low clears all stage valid bits and holds in_ch.ready low;
// the pipeline comes up empty.
// Stall: while out_ch.ready is low the output holds; earlier stages keep
// filling until every stage is occupied, then in_ch.ready drops. No item is
// lost or repeated.
module thumb_sub_register_execute (
  input logic       clk,
  input logic       rst_n,
  tsre_in_if.sink   in_ch,
  tsre_out_if.source out_ch
);
  import tsre_pkg::*;

  logic      v1_r, v2_r, v3_r;
  logic      en1, en2, en3;
  tsre_dec_t dec_nxt, s1_r;
  tsre_shf_t s2_nxt, s2_r;
  tsre_out_t s3_nxt, s3_r;
  logic [31:0] sh;
  logic [32:0] diff;
  logic [31:0] res;

  // Stage enables: advance when the next slot is free or draining
  assign en3 = !v3_r || out_ch.ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1 && rst_n;

  // Decode
  always_comb begin
    logic [31:0] ins;
    logic        s_bit;
    ins = in_ch.data.instruction;
    if (in_ch.data.opcode == ENC_WIDE) begin
      dec_nxt.rd     = ins[T2_RD_LO +: 4];
      dec_nxt.rn_idx = ins[T2_RN_LO +: 4];
      dec_nxt.rm_idx = ins[T2_RM_LO +: 4];
      dec_nxt.kind   = shift_kind_t'(ins[T2_TYPE_LO +: 2]);
      dec_nxt.amt    = {ins[T2_IMM3_LO +: 3], ins[T2_IMM2_LO +: 2]};
      dec_nxt.pc_adv = PC_ADV_WIDE;
      s_bit          = ins[T2_S_BIT];
    end else begin
      dec_nxt.rd     = {1'b0, ins[T1_RD_LO +: 3]};
      dec_nxt.rn_idx = {1'b0, ins[T1_RN_LO +: 3]};
      dec_nxt.rm_idx = {1'b0, ins[T1_RM_LO +: 3]};
      dec_nxt.kind   = SHIFT_LSL;
      dec_nxt.amt    = 5'd0;
      dec_nxt.pc_adv = PC_ADV_NARROW;
      s_bit          = !in_ch.data.in_it_block;
    end
    dec_nxt.exec = !in_ch.data.in_it_block || in_ch.data.condition_passed;
    dec_nxt.fw   = dec_nxt.exec && s_bit;
    dec_nxt.rn   = in_ch.data.rn_value;
    dec_nxt.rm   = in_ch.data.rm_value;
    dec_nxt.cin  = in_ch.data.carry_in;
  end

  // Shift
  tsre_shifter u_shifter (
    .x    (s1_r.rm),
    .kind (s1_r.kind),
    .amt  (s1_r.amt),
    .cin  (s1_r.cin),
    .y    (sh)
  );

  always_comb begin
    s2_nxt.rd     = s1_r.rd;
    s2_nxt.rn_idx = s1_r.rn_idx;
    s2_nxt.rm_idx = s1_r.rm_idx;
    s2_nxt.pc_adv = s1_r.pc_adv;
    s2_nxt.exec   = s1_r.exec;
    s2_nxt.fw     = s1_r.fw;
    s2_nxt.rn     = s1_r.rn;
    s2_nxt.sh     = sh;
  end

  // Subtract and flags; gate everything the instruction does not produce
  assign diff = {1'b0, s2_r.rn} - {1'b0, s2_r.sh};
  assign res  = diff[31:0];

  always_comb begin
    s3_nxt.dest_reg       = s2_r.rd;
    s3_nxt.result         = s2_r.exec ? res : 32'd0;
    s3_nxt.write_enable   = s2_r.exec;
    s3_nxt.flags_write    = s2_r.fw;
    s3_nxt.flag_n         = s2_r.fw && res[31];
    s3_nxt.flag_z         = s2_r.fw && (res == 32'd0);
    s3_nxt.flag_c         = s2_r.fw && !diff[32];
    s3_nxt.flag_v         = s2_r.fw && ((s2_r.rn[31] ^ s2_r.sh[31]) & (s2_r.rn[31] ^ res[31]));
    s3_nxt.pc_advance     = s2_r.pc_adv;
    s3_nxt.src_first_reg  = s2_r.rn_idx;
    s3_nxt.src_second_reg = s2_r.rm_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1_r <= dec_nxt;
    if (en2) s2_r <= s2_nxt;
    if (en3) s3_r <= s3_nxt;
  end

  assign out_ch.valid = v3_r;
  assign out_ch.data  = s3_r;

  // A held result must survive the stall
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !out_ch.ready |=> v3_r)
    else $error("output item dropped during stall");

  a_no_exec_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !s3_r.write_enable |-> s3_r.result == 32'd0 && !s3_r.flags_write)
    else $error("suppressed instruction has effects");

  a_flags_need_exec: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && s3_r.flags_write |-> s3_r.write_enable)
    else $error("flags written without execution");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && s3_r.flags_write |-> s3_r.flag_z == (s3_r.result == 32'd0))
    else $error("Z flag disagrees with result");

  a_pc_adv: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> s3_r.pc_advance == PC_ADV_NARROW || s3_r.pc_advance == PC_ADV_WIDE)
    else $error("bad PC increment");

endmodule

// ===== rtl/tsre_shifter.sv =====
// Shifter: immediate-shift decode of the second operand (LSL, LSR, ASR, ROR, RRX).
module tsre_shifter (
  input  logic [31:0]          x,
  input  tsre_pkg::shift_kind_t kind,
  input  logic [4:0]           amt,
  input  logic                 cin,
  output logic [31:0]          y
);
  import tsre_pkg::*;

  logic [63:0] rot;

  assign rot = {x, x} >> amt;

  always_comb begin
    unique case (kind)
      SHIFT_LSL: y = x << amt;
      SHIFT_LSR: y = (amt == 5'd0) ? 32'd0 : (x >> amt);
      SHIFT_ASR: y = (amt == 5'd0) ? {32{x[31]}} : $unsigned($signed(x) >>> amt);
      SHIFT_ROR: y = (amt == 5'd0) ? {cin, x[31:1]} : rot[31:0];
      default:   y = x;
    endcase
  end

endmodule

// ===== dv/tb_thumb_sub_register_execute.sv =====
// Testbench: checks the Thumb SUB (register) execute block against its own predictor.
module tb_thumb_sub_register_execute;
  import tsre_pkg::*;

  localparam int N_RANDOM    = 1200;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN       = 10;

  logic clk;
  logic rst_n;

  tsre_in_if  in_ch ();
  tsre_out_if out_ch ();

  thumb_sub_register_execute dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tsre_in_t  pending_instrs[$];
  tsre_out_t expected_results[$];

  int total_instrs;
  int issued;
  int retired;
  int mismatches;
  int in_gap;
  int out_stall;
  int hold_left;
  int n_narrow, n_wide, n_skipped, n_rrx;
  logic took_in;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Expected result of one SUB instruction.
  function automatic tsre_out_t predict_sub(tsre_in_t item);
    tsre_out_t   r;
    logic [3:0]  rd, rn_i, rm_i;
    logic        set_flags, runs, fw;
    shift_kind_t kind;
    logic [4:0]  amt;
    logic [31:0] sh, diff;
    logic [2:0]  adv;
    if (item.opcode == ENC_WIDE) begin
      rm_i      = item.instruction[3:0];
      rd        = item.instruction[11:8];
      rn_i      = item.instruction[19:16];
      set_flags = item.instruction[20];
      kind      = shift_kind_t'(item.instruction[5:4]);
      amt       = {item.instruction[14:12], item.instruction[7:6]};
      adv       = PC_ADV_WIDE;
    end else begin
      rm_i      = {1'b0, item.instruction[24:22]};
      rn_i      = {1'b0, item.instruction[21:19]};
      rd        = {1'b0, item.instruction[18:16]};
      set_flags = !item.in_it_block;
      kind      = SHIFT_LSL;
      amt       = 5'd0;
      adv       = PC_ADV_NARROW;
    end
    case (kind)
      SHIFT_LSL: sh = item.rm_value << amt;
      SHIFT_LSR: sh = (amt == 5'd0) ? 32'h0 : item.rm_value >> amt;
      SHIFT_ASR: begin
        if (amt == 5'd0) sh = {32{item.rm_value[31]}};
        else sh = $signed(item.rm_value) >>> amt;
      end
      default: begin
        // zero amount means rotate right by one through carry
        if (amt == 5'd0) sh = {item.carry_in, item.rm_value[31:1]};
        else sh = (item.rm_value >> amt) | (item.rm_value << (32 - int'(amt)));
      end
    endcase
    diff = item.rn_value - sh;
    runs = !item.in_it_block || item.condition_passed;
    fw   = runs && set_flags;
    r = '0;
    r.dest_reg       = rd;
    r.result         = runs ? diff : 32'h0;
    r.write_enable   = runs;
    r.flags_write    = fw;
    if (fw) begin
      r.flag_n = diff[31];
      r.flag_z = (diff == 32'h0);
      r.flag_c = (item.rn_value >= sh);
      r.flag_v = (item.rn_value[31] ^ sh[31]) & (item.rn_value[31] ^ diff[31]);
    end
    r.pc_advance     = adv;
    r.src_first_reg  = rn_i;
    r.src_second_reg = rm_i;
    return r;
  endfunction

  // Narrow halfword in bits 31:16; the ignored bits carry noise.
  function automatic logic [31:0] narrow_word(logic [2:0] rd, logic [2:0] rn, logic [2:0] rm);
    logic [31:0] w;
    w = $urandom;
    w[24:22] = rm;
    w[21:19] = rn;
    w[18:16] = rd;
    return w;
  endfunction

  function automatic logic [31:0] wide_word(logic s, logic [3:0] rn, logic [3:0] rd,
                                            logic [3:0] rm, shift_kind_t kind,
                                            logic [4:0] amt);
    logic [31:0] w;
    w = $urandom;
    w[20]    = s;
    w[19:16] = rn;
    w[14:12] = amt[4:2];
    w[11:8]  = rd;
    w[7:6]   = amt[1:0];
    w[5:4]   = kind;
    w[3:0]   = rm;
    return w;
  endfunction

  task automatic queue_instr(logic opc, logic [31:0] word, logic itb, logic cond,
                             logic [31:0] rnv, logic [31:0] rmv, logic cin);
    tsre_in_t item;
    item.opcode           = opc;
    item.instruction      = word;
    item.in_it_block      = itb;
    item.condition_passed = cond;
    item.rn_value         = rnv;
    item.rm_value         = rmv;
    item.carry_in         = cin;
    pending_instrs.push_back(item);
  endtask

  function automatic logic [31:0] pick_operand();
    logic [31:0] corner[4];
    logic [1:0]  sel;
    corner = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    sel = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 4) == 0) return corner[sel];
    return $urandom;
  endfunction

  task automatic check_result(tsre_out_t got);
    tsre_out_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result item, expected none, got %0h", $time, got);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      if (got !== want) begin
        $display("%0t: result item mismatch, expected %h, got %h", $time, want, got);
        mismatches++;
      end
    end
  endtask

  // Driver: present queued items, hold each until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      took_in = in_ch.valid && in_ch.ready;
      if (took_in) begin
        expected_results.push_back(predict_sub(in_ch.data));
        issued++;
        if (in_ch.data.opcode == ENC_WIDE) n_wide++;
        else n_narrow++;
        if (in_ch.data.in_it_block && !in_ch.data.condition_passed) n_skipped++;
        if (in_ch.data.opcode == ENC_WIDE && in_ch.data.instruction[5:4] == SHIFT_ROR &&
            in_ch.data.instruction[14:12] == 3'd0 && in_ch.data.instruction[7:6] == 2'd0)
          n_rrx++;
      end
      if (took_in || !in_ch.valid) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_instrs.size() != 0) begin
          in_ch.data  <= pending_instrs.pop_front();
          in_ch.valid <= 1'b1;
          in_gap = issued[6] ? $urandom_range(0, 3) : 0;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result item, stall at random, hold off twice for long.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_result(out_ch.data);
        retired++;
        out_stall = retired[5] ? $urandom_range(0, 3) : 0;
        if (retired == 300 || retired == 900) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic        wide, itb, cond, cin;
    logic [4:0]  amt;
    logic [31:0] rnv, rmv;
    logic [31:0] rnd;
    shift_kind_t kind;

    rst_n = 1'b0;

    // narrow form: flag setting outside IT, silent inside, suppressed on a failed condition
    queue_instr(ENC_NARROW, narrow_word(3'd0, 3'd0, 3'd0), 1'b0, 1'b0, 32'h0, 32'h0, 1'b0);
    queue_instr(ENC_NARROW, narrow_word(3'd1, 3'd2, 3'd3), 1'b0, 1'b1, 32'h0, 32'h1, 1'b1);
    queue_instr(ENC_NARROW, narrow_word(3'd7, 3'd7, 3'd7), 1'b0, 1'b0,
                32'h8000_0000, 32'h1, 1'b0);
    queue_instr(ENC_NARROW, narrow_word(3'd7, 3'd0, 3'd7), 1'b1, 1'b1,
                32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    queue_instr(ENC_NARROW, narrow_word(3'd5, 3'd6, 3'd4), 1'b1, 1'b0,
                32'h1234_5678, 32'h0000_0001, 1'b1);
    // wide form: every shift kind at both amount extremes
    for (int k = 0; k < 4; k++) begin
      queue_instr(ENC_WIDE, wide_word(1'b1, 4'd15, 4'd0, 4'd15, shift_kind_t'(k), 5'd0),
                  1'b0, 1'b0, 32'h7FFF_FFFF, 32'h8000_0001, 1'b1);
      queue_instr(ENC_WIDE, wide_word(1'b1, 4'd0, 4'd15, 4'd0, shift_kind_t'(k), 5'd31),
                  1'b0, 1'b0, 32'h7FFF_FFFF, 32'h8000_0001, 1'b0);
    end
    // rotate through carry with carry clear, then an ordinary rotate and mid shifts
    queue_instr(ENC_WIDE, wide_word(1'b1, 4'd3, 4'd4, 4'd5, SHIFT_ROR, 5'd0),
                1'b0, 1'b0, 32'h0, 32'hFFFF_FFFE, 1'b0);
    queue_instr(ENC_WIDE, wide_word(1'b1, 4'd8, 4'd9, 4'd10, SHIFT_ROR, 5'd5),
                1'b0, 1'b0, 32'h8000_0000, 32'hF000_000F, 1'b1);
    queue_instr(ENC_WIDE, wide_word(1'b1, 4'd1, 4'd2, 4'd3, SHIFT_LSR, 5'd1),
                1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_instr(ENC_WIDE, wide_word(1'b1, 4'd6, 4'd7, 4'd8, SHIFT_ASR, 5'd16),
                1'b0, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    queue_instr(ENC_WIDE, wide_word(1'b1, 4'd11, 4'd12, 4'd13, SHIFT_LSL, 5'd17),
                1'b0, 1'b0, 32'h0000_0001, 32'h0001_0001, 1'b1);
    // flags off with S clear; IT block failed and passed
    queue_instr(ENC_WIDE, wide_word(1'b0, 4'd2, 4'd14, 4'd9, SHIFT_LSL, 5'd3),
                1'b0, 1'b0, 32'h0, 32'h1, 1'b0);
    queue_instr(ENC_WIDE, wide_word(1'b1, 4'd4, 4'd13, 4'd6, SHIFT_ASR, 5'd0),
                1'b1, 1'b0, 32'h0, 32'h8000_0000, 1'b1);
    queue_instr(ENC_WIDE, wide_word(1'b1, 4'd12, 4'd1, 4'd14, SHIFT_LSR, 5'd0),
                1'b1, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    queue_instr(ENC_WIDE, wide_word(1'b1, 4'd15, 4'd15, 4'd15, SHIFT_LSL, 5'd0),
                1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);

    for (int i = 0; i < N_RANDOM; i++) begin
      rnd  = $urandom;
      wide = rnd[0];
      itb  = ($urandom_range(0, 2) == 0);
      cond = rnd[1];
      cin  = rnd[2];
      rnv  = pick_operand();
      rmv  = ($urandom_range(0, 9) == 0) ? rnv : pick_operand();
      kind = shift_kind_t'(rnd[31:30]);
      case ($urandom_range(0, 7))
        0, 1:    amt = 5'd0;
        2:       amt = 5'd31;
        default: amt = rnd[7:3];
      endcase
      if (wide)
        queue_instr(ENC_WIDE, wide_word(rnd[8], rnd[12:9], rnd[16:13], rnd[20:17],
                                        kind, amt), itb, cond, rnv, rmv, cin);
      else
        queue_instr(ENC_NARROW, narrow_word(rnd[23:21], rnd[26:24], rnd[29:27]),
                    itb, cond, rnv, rmv, cin);
    end
    total_instrs = pending_instrs.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (issued < total_instrs) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Ran %0d SUB instructions: %0d narrow, %0d wide, %0d of them rotate-with-carry.",
             issued, n_narrow, n_wide, n_rrx);
    $display("%0d were suppressed by a failed IT condition; %0d result items checked.",
             n_skipped, retired);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
